// ===== design/salru_pkg.sv =====
package salru_pkg;

    localparam int ADDR_WIDTH_DEF   = 32;
    localparam int MAX_SET_BITS_DEF = 10;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int CFG_DATA_W       = 6;
    localparam int CFG_IDX_W        = 2;
    localparam int MISS_W           = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SET_INDEX_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS    = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic read;
        logic update;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
    } ctrl_sts_t;

endpackage

// ===== design/salru_ctrl.sv =====
module salru_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output salru_pkg::ctrl_cmd_t cmd,
    input  salru_pkg::ctrl_sts_t sts
);
    import salru_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (sts.clear_done) state_next = ST_IDLE;
            ST_IDLE:   if (in_valid) state_next = ST_READ;
            ST_READ:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = in_valid ? ST_READ : ST_IDLE;
                end
            end
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        cmd            = '0;
        case (state_reg)
            ST_CLEAR:  cmd.clear_step = 1'b1;
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_READ:   cmd.read = 1'b1;
            ST_UPDATE: cmd.update = 1'b1;
            ST_OUT:
            begin
                out_valid   = 1'b1;
                in_ready    = out_ready;
                cmd.capture = out_ready & in_valid;
            end
            default:   cmd = '0;
        endcase
    end

endmodule

// ===== design/salru_dp.sv =====
module salru_dp
#(
    parameter int ADDR_WIDTH   = salru_pkg::ADDR_WIDTH_DEF,
    parameter int MAX_SET_BITS = salru_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = salru_pkg::MAX_WAYS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_idx,
    input  logic [5:0]             cfg_data,
    input  logic [ADDR_WIDTH-1:0]  address,
    output logic                   hit,
    output logic [31:0]            miss_total,
    input  salru_pkg::ctrl_cmd_t   cmd,
    output salru_pkg::ctrl_sts_t   sts
);
    import salru_pkg::*;

    localparam int SETS  = 1 << MAX_SET_BITS;
    localparam int WB    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RW    = WB;
    localparam int AWB   = $clog2(ADDR_WIDTH + 1);
    localparam int SBW   = $clog2(MAX_SET_BITS + 1);
    localparam int WCW   = $clog2(MAX_WAYS + 1);
    localparam int WAYW  = ADDR_WIDTH + 1 + RW;
    localparam logic [RW-1:0] RMAX = RW'(MAX_WAYS - 1);

    typedef logic [WAYW-1:0] way_t;

    logic [5:0] abits_reg;
    logic [3:0] sbits_reg;
    logic [3:0] ways_reg;
    logic [4:0] obits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abits_reg <= 6'd32;
            sbits_reg <= 4'd0;
            ways_reg  <= 4'd1;
            obits_reg <= 5'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_ADDRESS_BITS:   abits_reg <= cfg_data;
                REG_SET_INDEX_BITS: sbits_reg <= cfg_data[3:0];
                REG_WAYS_IN_USE:    ways_reg  <= cfg_data[3:0];
                REG_OFFSET_BITS:    obits_reg <= cfg_data[4:0];
                default:            abits_reg <= abits_reg;
            endcase
        end
    end

    // effective field widths
    logic [AWB-1:0] a_eff;
    logic [AWB-1:0] sb_eff;
    logic [AWB-1:0] ob_eff;
    logic [WCW-1:0] w_eff;
    always_comb
    begin
        if (abits_reg == 6'd0)
            a_eff = AWB'(1);
        else if (32'(abits_reg) > ADDR_WIDTH)
            a_eff = AWB'(ADDR_WIDTH);
        else
            a_eff = AWB'(abits_reg);
        if (32'(sbits_reg) > MAX_SET_BITS)
            sb_eff = AWB'(MAX_SET_BITS);
        else
            sb_eff = AWB'(sbits_reg);
        if (sb_eff > a_eff)
            sb_eff = a_eff;
        if (32'(obits_reg) > 32'(a_eff - sb_eff))
            ob_eff = a_eff - sb_eff;
        else
            ob_eff = AWB'(obits_reg);
        if (ways_reg == 4'd0)
            w_eff = WCW'(1);
        else if (32'(ways_reg) > MAX_WAYS)
            w_eff = WCW'(MAX_WAYS);
        else
            w_eff = WCW'(ways_reg);
    end

    logic [ADDR_WIDTH-1:0]   addr_reg;
    logic [ADDR_WIDTH-1:0]   addr_m;
    logic [ADDR_WIDTH-1:0]   tag_c;
    logic [MAX_SET_BITS-1:0] set_c;
    logic [ADDR_WIDTH-1:0]   mask_a;
    logic [ADDR_WIDTH-1:0]   set_sh;
    logic [ADDR_WIDTH:0]     one_sb;

    always_comb
    begin
        mask_a = '1;
        if (32'(a_eff) < ADDR_WIDTH)
            mask_a = ~({ADDR_WIDTH{1'b1}} << a_eff);
        addr_m = addr_reg & mask_a;
        tag_c  = '0;
        if (32'(sb_eff) + 32'(ob_eff) < ADDR_WIDTH)
            tag_c = addr_m >> (sb_eff + ob_eff);
        set_sh = addr_m >> ob_eff;
        one_sb = (ADDR_WIDTH + 1)'(1) << sb_eff;
        set_c  = set_sh[MAX_SET_BITS-1:0] & MAX_SET_BITS'(one_sb - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg <= address;
        end
    end

    // set store: one row per set, all ways in a row
    way_t [MAX_WAYS-1:0]     mem [SETS];
    way_t [MAX_WAYS-1:0]     row_reg;
    logic [MAX_SET_BITS-1:0] set_reg;
    logic [ADDR_WIDTH-1:0]   tag_reg;
    logic [MAX_SET_BITS:0]   clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end
    assign sts.clear_done = cmd.clear_step && (clr_reg == (MAX_SET_BITS+1)'(SETS - 1));

    // per-way fields of the current row
    logic [MAX_WAYS-1:0]           v_w;
    logic [MAX_WAYS-1:0]           use_w;
    logic [MAX_WAYS-1:0]           match_w;
    logic [MAX_WAYS-1:0][RW-1:0]   r_w;
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] t_w;
    always_comb
    begin
        for (int j = 0; j < MAX_WAYS; j++)
        begin
            t_w[j]     = row_reg[j][WAYW-1 -: ADDR_WIDTH];
            v_w[j]     = row_reg[j][RW];
            r_w[j]     = row_reg[j][RW-1:0];
            use_w[j]   = (j < 32'(w_eff));
            match_w[j] = use_w[j] & v_w[j] & (t_w[j] == tag_reg);
        end
    end

    logic          found;
    logic [WB-1:0] hit_way;
    logic          free_found;
    logic [WB-1:0] free_way;
    logic [WB-1:0] lru_way;
    logic [RW-1:0] lru_best;
    logic [WB-1:0] k_way;
    logic [RW:0]   k_rank;
    always_comb
    begin
        found      = 1'b0;
        hit_way    = '0;
        free_found = 1'b0;
        free_way   = '0;
        lru_way    = '0;
        lru_best   = r_w[0];
        for (int j = MAX_WAYS - 1; j >= 0; j--)
        begin
            if (match_w[j])
            begin
                found   = 1'b1;
                hit_way = WB'(j);
            end
            if (use_w[j] && !v_w[j])
            begin
                free_found = 1'b1;
                free_way   = WB'(j);
            end
        end
        for (int j = 1; j < MAX_WAYS; j++)
        begin
            if (use_w[j] && r_w[j] > lru_best)
            begin
                lru_best = r_w[j];
                lru_way  = WB'(j);
            end
        end
        if (found)
        begin
            k_way  = hit_way;
            k_rank = {1'b0, r_w[hit_way]};
        end
        else if (free_found)
        begin
            k_way  = free_way;
            k_rank = (RW+1)'(MAX_WAYS);
        end
        else
        begin
            k_way  = lru_way;
            k_rank = {1'b0, r_w[lru_way]};
        end
    end

    way_t [MAX_WAYS-1:0] row_new;
    always_comb
    begin
        for (int j = 0; j < MAX_WAYS; j++)
        begin
            row_new[j] = row_reg[j];
            if (WB'(j) == k_way)
            begin
                row_new[j] = {(found ? t_w[j] : tag_reg), 1'b1, {RW{1'b0}}};
            end
            else if (use_w[j] && v_w[j] && ({1'b0, r_w[j]} < k_rank) && (r_w[j] < RMAX))
            begin
                row_new[j][RW-1:0] = r_w[j] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            mem[clr_reg[MAX_SET_BITS-1:0]] <= '0;
        end
        else if (cmd.update)
        begin
            mem[set_reg] <= row_new;
        end
        if (cmd.read)
        begin
            row_reg <= mem[set_c];
            set_reg <= set_c;
            tag_reg <= tag_c;
        end
    end

    logic        hit_reg;
    logic [31:0] miss_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            miss_reg <= '0;
        end
        else if (cmd.update)
        begin
            hit_reg <= found;
            if (!found && miss_reg != '1)
                miss_reg <= miss_reg + 1'b1;
        end
    end

    assign hit        = hit_reg;
    assign miss_total = miss_reg;

endmodule

// ===== design/set_assoc_lru_cache_lookup.sv =====
// Set-associative cache lookup with LRU replacement.
// Input channel: address with in_valid/in_ready; one word is one reference.
// Output channel: hit and miss_total with out_valid/out_ready.
// Configuration: cfg_we, cfg_idx, cfg_data; write only while idle.
// Each word passes set row read, compare and row write-back, then the result
// register. The next word is taken in the cycle its predecessor's result is
// taken, so a new word is not accepted before the last one is through; this is
// set by the single-port set store (read, then write back).
// A stalled receiver holds the result and blocks new input.
// After reset all 2**MAX_SET_BITS sets (1024 by default) of the store are swept
// to invalid one set per cycle; in_ready stays low meanwhile.
// Miss count and configuration return to their reset values.
module set_assoc_lru_cache_lookup
#(
    parameter int ADDR_WIDTH   = salru_pkg::ADDR_WIDTH_DEF,
    parameter int MAX_SET_BITS = salru_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = salru_pkg::MAX_WAYS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ADDR_WIDTH-1:0] address,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  hit,
    output logic [31:0]           miss_total,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_idx,
    input  logic [5:0]            cfg_data
);
    import salru_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    salru_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    salru_dp #(
        .ADDR_WIDTH   (ADDR_WIDTH),
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .address    (address),
        .hit        (hit),
        .miss_total (miss_total),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule
